### hdl/rmq_pkg.sv
// Shared constants and width helpers for the rotation matrix to quaternion block.
// No dependencies; every other file imports this package.
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W          = 18;
	localparam int OUT_W         = 18;
	localparam int N_COMP        = 4;
	localparam int NORM_TOP      = 29;
	localparam int NORM_STEPS    = 5;
	localparam int FIFO_DEPTH    = 2;

	// magnitude of any scaled component before normalization
	function automatic int mag_w(input int f);
		return ((f > 19) ? f : 19) + 1;
	endfunction

	// width of a normalized magnitude
	function automatic int norm_w(input int f);
		return (mag_w(f) > NORM_TOP + 1) ? mag_w(f) : NORM_TOP + 1;
	endfunction

	// sum of four squares of normalized magnitudes
	function automatic int sum_w(input int f);
		return 2 * norm_w(f) + 2;
	endfunction

	function automatic int root_w(input int f);
		return norm_w(f) + 1;
	endfunction

	// classified item: degenerate flag and four signed components
	function automatic int item_w(input int f);
		return 1 + N_COMP * (mag_w(f) + 1);
	endfunction

endpackage

### hdl/rmq_front.sv
// Front end: registers an accepted matrix, picks the leading axis and forms
// the four scaled quaternion components. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [IN_W-1:0]        m00,
	input  logic signed [IN_W-1:0]        m01,
	input  logic signed [IN_W-1:0]        m02,
	input  logic signed [IN_W-1:0]        m10,
	input  logic signed [IN_W-1:0]        m11,
	input  logic signed [IN_W-1:0]        m12,
	input  logic signed [IN_W-1:0]        m20,
	input  logic signed [IN_W-1:0]        m21,
	input  logic signed [IN_W-1:0]        m22,
	input  logic                          full,
	output logic                          push,
	output logic [item_w(FRAC_BITS)-1:0]  item
);

	localparam int UW = mag_w(FRAC_BITS) + 1;
	localparam logic signed [UW-1:0] ONE = UW'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		AX_0 = 2'd0,
		AX_1 = 2'd1,
		AX_2 = 2'd2
	} axis_t;

	logic                   vld_s1;
	logic signed [IN_W-1:0] m_s1 [9];
	logic signed [UW-1:0]   e [9];
	logic signed [UW-1:0]   trace;
	logic signed [UW-1:0]   a;
	logic signed [UW-1:0]   u [N_COMP];
	logic                   pos;
	logic                   deg;
	logic                   accept;
	axis_t                  axis;

	assign busy   = vld_s1 & full;
	assign accept = start & ~busy;
	assign push   = vld_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_s1 <= '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
		end
	end

	for (genvar n = 0; n < 9; n++) begin : g_ext
		assign e[n] = UW'(m_s1[n]);
	end

	assign trace = e[0] + e[4] + e[8];
	assign pos   = trace > 0;

	// largest diagonal entry, ties to the lower index
	always_comb begin
		axis = AX_0;
		if (e[4] > e[0]) begin
			axis = AX_1;
		end
		if (e[8] > ((axis == AX_1) ? e[4] : e[0])) begin
			axis = AX_2;
		end
	end

	always_comb begin
		a = '0;
		for (int n = 0; n < N_COMP; n++) begin
			u[n] = '0;
		end
		unique case (axis)
			AX_0: begin
				a    = e[0] - e[4] - e[8] + ONE;
				u[0] = a;
				u[3] = e[7] - e[5];
				u[1] = e[3] + e[1];
				u[2] = e[6] + e[2];
			end
			AX_1: begin
				a    = e[4] - e[8] - e[0] + ONE;
				u[1] = a;
				u[3] = e[2] - e[6];
				u[2] = e[7] + e[5];
				u[0] = e[1] + e[3];
			end
			AX_2: begin
				a    = e[8] - e[0] - e[4] + ONE;
				u[2] = a;
				u[3] = e[3] - e[1];
				u[0] = e[2] + e[6];
				u[1] = e[5] + e[7];
			end
			default: begin
				a = '0;
			end
		endcase
		if (pos) begin
			u[0] = (e[7] - e[5]) <<< 1;
			u[1] = (e[2] - e[6]) <<< 1;
			u[2] = (e[3] - e[1]) <<< 1;
			u[3] = trace + ONE;
		end
	end

	assign deg  = ~pos & (a <= 0);
	assign item = {deg, u[3], u[2], u[1], u[0]};

endmodule

### hdl/rmq_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on rmq_pkg for its depth.
module rmq_fifo import rmq_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	output logic          vld,
	output logic [DW-1:0] rdata
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [DW-1:0] mem_q [FIFO_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(FIFO_DEPTH);
	assign vld   = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			// the back end never stalls: drop the head every cycle it is there
			if (vld) begin
				rp_q <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(vld);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

### hdl/rmq_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side bus
// that travels alongside. Depends on rmq_pkg.
module rmq_isqrt import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SBW       = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [sum_w(FRAC_BITS)-1:0]   radicand,
	input  logic [SBW-1:0]                in_sb,
	output logic                          out_vld,
	output logic [root_w(FRAC_BITS)-1:0]  root,
	output logic [SBW-1:0]                out_sb
);

	localparam int SW = sum_w(FRAC_BITS);
	localparam int RW = root_w(FRAC_BITS);

	logic [SW-1:0]  rem_s [RW+1];
	logic [RW-1:0]  rt_s  [RW+1];
	logic [SBW-1:0] sb_s  [RW+1];
	logic [RW:0]    vld_s;

	assign rem_s[0] = radicand;
	assign rt_s[0]  = '0;
	assign sb_s[0]  = in_sb;
	assign vld_s[0] = in_vld;

	for (genvar st = 0; st < RW; st++) begin : g_st
		localparam int B = RW - 1 - st;
		logic [SW-1:0] trial;
		logic          fit;

		// (r + 2^B)^2 - r^2, with r holding only bits above B
		assign trial = (SW'(rt_s[st]) << (B + 1)) | (SW'(1) << (2 * B));
		assign fit   = rem_s[st] >= trial;

		always_ff @(posedge clk) begin
			rem_s[st+1] <= fit ? rem_s[st] - trial : rem_s[st];
			rt_s[st+1]  <= fit ? (rt_s[st] | (RW'(1) << B)) : rt_s[st];
			sb_s[st+1]  <= sb_s[st];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st+1] <= 1'b0;
			end else begin
				vld_s[st+1] <= vld_s[st];
			end
		end
	end

	assign out_vld = vld_s[RW];
	assign root    = rt_s[RW];
	assign out_sb  = sb_s[RW];

endmodule

### hdl/rmq_back.sv
// Back end: magnitudes, normalizing shift, sum of squares, root, per-component
// division by the length and the output register. Depends on rmq_pkg, rmq_isqrt.
module rmq_back import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [item_w(FRAC_BITS)-1:0]  item,
	output logic                          done,
	output logic signed [OUT_W-1:0]       quat_x,
	output logic signed [OUT_W-1:0]       quat_y,
	output logic signed [OUT_W-1:0]       quat_z,
	output logic signed [OUT_W-1:0]       quat_w,
	output logic                          degenerate
);

	localparam int UW  = mag_w(FRAC_BITS) + 1;
	localparam int NW  = norm_w(FRAC_BITS);
	localparam int SW  = sum_w(FRAC_BITS);
	localparam int RW  = root_w(FRAC_BITS);
	localparam int QB  = FRAC_BITS + 1;
	localparam int DNW = NW + FRAC_BITS + 1;
	localparam int QW  = (FRAC_BITS + 2 > OUT_W) ? FRAC_BITS + 2 : OUT_W;
	localparam int SBW = 1 + N_COMP + N_COMP * NW;
	localparam logic [QW-1:0] IDENT = QW'(1) << FRAC_BITS;

	// s1: magnitudes and signs
	logic signed [UW-1:0] u_in  [N_COMP];
	logic signed [UW-1:0] u_abs [N_COMP];
	logic [NW-1:0]        mag_s1 [N_COMP];
	logic [N_COMP-1:0]    neg_s1;
	logic                 deg_s1;
	logic                 vld_s1;

	for (genvar n = 0; n < N_COMP; n++) begin : g_abs
		assign u_in[n]  = item[n*UW +: UW];
		assign u_abs[n] = u_in[n][UW-1] ? -u_in[n] : u_in[n];
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < N_COMP; n++) begin
			mag_s1[n] <= NW'(u_abs[n][UW-2:0]);
			neg_s1[n] <= u_in[n][UW-1];
		end
		deg_s1 <= item[N_COMP*UW];
	end

	// s2: largest magnitude; nrm_*_s[0] is this stage, [k] are s2+k
	logic [NW-1:0]     mx01;
	logic [NW-1:0]     mx23;
	logic [NW-1:0]     nrm_mag_s [NORM_STEPS+1][N_COMP];
	logic [NW-1:0]     nrm_mx_s  [NORM_STEPS+1];
	logic [N_COMP-1:0] nrm_neg_s [NORM_STEPS+1];
	logic              nrm_deg_s [NORM_STEPS+1];
	logic [NORM_STEPS:0] nrm_vld_s;

	assign mx01 = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];
	assign mx23 = (mag_s1[3] > mag_s1[2]) ? mag_s1[3] : mag_s1[2];

	always_ff @(posedge clk) begin
		nrm_mx_s[0]  <= (mx23 > mx01) ? mx23 : mx01;
		nrm_mag_s[0] <= mag_s1;
		nrm_neg_s[0] <= neg_s1;
		nrm_deg_s[0] <= deg_s1;
	end

	// shift by 16, 8, 4, 2, 1 while the largest stays below 2^30
	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_nrm
		localparam int STEP = 1 << (NORM_STEPS - 1 - k);
		logic go;

		assign go = nrm_mx_s[k] < (NW'(1) << (NORM_TOP + 1 - STEP));

		always_ff @(posedge clk) begin
			nrm_mx_s[k+1] <= go ? nrm_mx_s[k] << STEP : nrm_mx_s[k];
			for (int n = 0; n < N_COMP; n++) begin
				nrm_mag_s[k+1][n] <= go ? nrm_mag_s[k][n] << STEP : nrm_mag_s[k][n];
			end
			nrm_neg_s[k+1] <= nrm_neg_s[k];
			nrm_deg_s[k+1] <= nrm_deg_s[k];
		end
	end

	// s8: squares, s9: pair sums, s10: full sum
	logic [2*NW-1:0]   sq_s8  [N_COMP];
	logic [NW-1:0]     mag_s8 [N_COMP];
	logic [NW-1:0]     mag_s9 [N_COMP];
	logic [NW-1:0]     mag_s10 [N_COMP];
	logic [SW-1:0]     ps_s9 [2];
	logic [SW-1:0]     sum_s10;
	logic [N_COMP-1:0] neg_s8, neg_s9, neg_s10;
	logic              deg_s8, deg_s9, deg_s10;
	logic              vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk) begin
		for (int n = 0; n < N_COMP; n++) begin
			sq_s8[n] <= (2*NW)'(nrm_mag_s[NORM_STEPS][n]) *
				(2*NW)'(nrm_mag_s[NORM_STEPS][n]);
		end
		mag_s8  <= nrm_mag_s[NORM_STEPS];
		neg_s8  <= nrm_neg_s[NORM_STEPS];
		deg_s8  <= nrm_deg_s[NORM_STEPS];
		ps_s9[0] <= SW'(sq_s8[0]) + SW'(sq_s8[1]);
		ps_s9[1] <= SW'(sq_s8[2]) + SW'(sq_s8[3]);
		mag_s9  <= mag_s8;
		neg_s9  <= neg_s8;
		deg_s9  <= deg_s8;
		sum_s10 <= ps_s9[0] + ps_s9[1];
		mag_s10 <= mag_s9;
		neg_s10 <= neg_s9;
		deg_s10 <= deg_s9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			nrm_vld_s <= '0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
		end else begin
			vld_s1    <= in_vld;
			nrm_vld_s <= {nrm_vld_s[NORM_STEPS-1:0], vld_s1};
			vld_s8    <= nrm_vld_s[NORM_STEPS];
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
		end
	end

	// root of the sum of squares gives the length
	logic [SBW-1:0] sb_in;
	logic [SBW-1:0] sb_out;
	logic [RW-1:0]  len;
	logic           rt_vld;

	for (genvar n = 0; n < N_COMP; n++) begin : g_sb
		assign sb_in[n*NW +: NW] = mag_s10[n];
	end
	assign sb_in[SBW-1 -: 1 + N_COMP] = {deg_s10, neg_s10};

	rmq_isqrt #(
		.FRAC_BITS (FRAC_BITS),
		.SBW       (SBW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s10),
		.radicand (sum_s10),
		.in_sb    (sb_in),
		.out_vld  (rt_vld),
		.root     (len),
		.out_sb   (sb_out)
	);

	// restoring division, one quotient bit per stage, rounding by adding len/2
	logic [DNW-1:0]    drem_s [QB+1][N_COMP];
	logic [QB-1:0]     dq_s   [QB+1][N_COMP];
	logic [RW-1:0]     dlen_s [QB+1];
	logic [N_COMP-1:0] dneg_s [QB+1];
	logic              ddeg_s [QB+1];
	logic [QB:0]       dvld_s;

	for (genvar n = 0; n < N_COMP; n++) begin : g_num
		assign drem_s[0][n] = (DNW'(sb_out[n*NW +: NW]) << FRAC_BITS) + DNW'(len >> 1);
		assign dq_s[0][n]   = '0;
	end
	assign dlen_s[0] = len;
	assign dneg_s[0] = sb_out[N_COMP*NW +: N_COMP];
	assign ddeg_s[0] = sb_out[SBW-1];
	assign dvld_s[0] = rt_vld;

	for (genvar st = 0; st < QB; st++) begin : g_div
		localparam int B = FRAC_BITS - st;
		logic [DNW-1:0] dv;

		assign dv = DNW'(dlen_s[st]) << B;

		always_ff @(posedge clk) begin
			for (int n = 0; n < N_COMP; n++) begin
				if (drem_s[st][n] >= dv) begin
					drem_s[st+1][n] <= drem_s[st][n] - dv;
					dq_s[st+1][n]   <= dq_s[st][n] | (QB'(1) << B);
				end else begin
					drem_s[st+1][n] <= drem_s[st][n];
					dq_s[st+1][n]   <= dq_s[st][n];
				end
			end
			dlen_s[st+1] <= dlen_s[st];
			dneg_s[st+1] <= dneg_s[st];
			ddeg_s[st+1] <= ddeg_s[st];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[st+1] <= 1'b0;
			end else begin
				dvld_s[st+1] <= dvld_s[st];
			end
		end
	end

	// apply signs, keep the low field bits, or give the identity on failure
	logic [QW-1:0] qv [N_COMP];

	for (genvar n = 0; n < N_COMP; n++) begin : g_sgn
		assign qv[n] = dneg_s[QB][n] ? -QW'(dq_s[QB][n]) : QW'(dq_s[QB][n]);
	end

	always_ff @(posedge clk) begin
		if (ddeg_s[QB]) begin
			quat_x <= '0;
			quat_y <= '0;
			quat_z <= '0;
			quat_w <= IDENT[OUT_W-1:0];
		end else begin
			quat_x <= qv[0][OUT_W-1:0];
			quat_y <= qv[1][OUT_W-1:0];
			quat_z <= qv[2][OUT_W-1:0];
			quat_w <= qv[3][OUT_W-1:0];
		end
		degenerate <= ddeg_s[QB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvld_s[QB];
		end
	end

endmodule

### hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, fixed point, fully pipelined.
// Throughput: one matrix per cycle; busy rises only if the queue backs up.
// An accepted matrix passes the front register, the queue, the back-end magnitude,
// normalizing, square and sum stages, the bit-serial root and divider, then the output register.
// Results cannot be held off; each shows for one cycle with done high.
// Reset (arst_n low) clears every valid bit and the queue; items in flight are dropped.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  m00,
	input  logic signed [IN_W-1:0]  m01,
	input  logic signed [IN_W-1:0]  m02,
	input  logic signed [IN_W-1:0]  m10,
	input  logic signed [IN_W-1:0]  m11,
	input  logic signed [IN_W-1:0]  m12,
	input  logic signed [IN_W-1:0]  m20,
	input  logic signed [IN_W-1:0]  m21,
	input  logic signed [IN_W-1:0]  m22,
	output logic                    done,
	output logic signed [OUT_W-1:0] quat_x,
	output logic signed [OUT_W-1:0] quat_y,
	output logic signed [OUT_W-1:0] quat_z,
	output logic signed [OUT_W-1:0] quat_w,
	output logic                    degenerate
);

	localparam int IW = item_w(FRAC_BITS);

	logic          full;
	logic          push;
	logic [IW-1:0] item_f;
	logic          q_vld;
	logic [IW-1:0] item_b;

	rmq_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.m00    (m00),
		.m01    (m01),
		.m02    (m02),
		.m10    (m10),
		.m11    (m11),
		.m12    (m12),
		.m20    (m20),
		.m21    (m21),
		.m22    (m22),
		.full   (full),
		.push   (push),
		.item   (item_f)
	);

	rmq_fifo #(
		.DW (IW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item_f),
		.full   (full),
		.vld    (q_vld),
		.rdata  (item_b)
	);

	rmq_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (q_vld),
		.item       (item_b),
		.done       (done),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w),
		.degenerate (degenerate)
	);

endmodule

### bench/rotation_matrix_to_quaternion_test.sv
// Self-checking bench for the rotation matrix to quaternion block.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; the scoreboard class holds its own
// fixed-point model of the conversion.
typedef logic signed [rmq_pkg::IN_W-1:0] elem_t;
typedef elem_t mat_t [9];

typedef struct packed {
	logic signed [rmq_pkg::OUT_W-1:0] x, y, z, w;
	logic                             degen;
} quat_t;

class quat_scoreboard;
	quat_t pending[$];
	int    mismatches;

	static function bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v    = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	static function quat_t identity();
		quat_t q;
		q = '0;
		q.w[rmq_pkg::FRAC_BITS_DEF] = 1'b1;
		q.degen = 1'b1;
		return q;
	endfunction

	static function quat_t quat_from_matrix(mat_t a);
		longint    m [3][3];
		longint    u [4];
		bit [63:0] mag [4];
		bit        neg [4];
		bit [63:0] mx, sum, len, q;
		longint    one, tr, arg;
		int        i, j, k;
		logic signed [rmq_pkg::OUT_W-1:0] res [4];
		quat_t     qt;
		one = longint'(1) << rmq_pkg::FRAC_BITS_DEF;
		for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'(a[n]);
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			u[0] = 2 * (m[2][1] - m[1][2]);
			u[1] = 2 * (m[0][2] - m[2][0]);
			u[2] = 2 * (m[1][0] - m[0][1]);
			u[3] = tr + one;
		end else begin
			// largest diagonal leads, ties go to the lower axis
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			arg = m[i][i] - m[j][j] - m[k][k] + one;
			if (arg <= 0) return identity();
			u[i] = arg;
			u[3] = m[k][j] - m[j][k];
			u[j] = m[j][i] + m[i][j];
			u[k] = m[k][i] + m[i][k];
		end
		mx = 0;
		for (int n = 0; n < 4; n++) begin
			neg[n] = u[n] < 0;
			mag[n] = neg[n] ? -u[n] : u[n];
			if (mag[n] > mx) mx = mag[n];
		end
		if (mx == 0) return identity();
		while (mx < (64'd1 << rmq_pkg::NORM_TOP)) begin
			mx <<= 1;
			for (int n = 0; n < 4; n++) mag[n] <<= 1;
		end
		sum = 0;
		for (int n = 0; n < 4; n++) sum += mag[n] * mag[n];
		len = int_sqrt(sum);
		if (len == 0) return identity();
		for (int n = 0; n < 4; n++) begin
			q = ((mag[n] << rmq_pkg::FRAC_BITS_DEF) + (len >> 1)) / len;
			if (neg[n]) q = -q;
			res[n] = q[rmq_pkg::OUT_W-1:0];
		end
		qt.x = res[0]; qt.y = res[1]; qt.z = res[2]; qt.w = res[3];
		qt.degen = 1'b0;
		return qt;
	endfunction

	function void note_matrix(mat_t a);
		pending.push_back(quat_from_matrix(a));
	endfunction

	function void check_quat(quat_t got);
		quat_t exp;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result x=%0d y=%0d z=%0d w=%0d deg=%0b",
					got.x, got.y, got.z, got.w, got.degen);
			return;
		end
		exp = pending.pop_front();
		if (got !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: exp x=%0d y=%0d z=%0d w=%0d deg=%0b, ",
					"got x=%0d y=%0d z=%0d w=%0d deg=%0b"},
					exp.x, exp.y, exp.z, exp.w, exp.degen,
					got.x, got.y, got.z, got.w, got.degen);
		end
	endfunction
endclass

module rotation_matrix_to_quaternion_test;
	import rmq_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int ONE = 1 << FRAC_BITS_DEF;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, degenerate;
	elem_t m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m20 = 0, m21 = 0, m22 = 0;
	logic signed [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;

	quat_scoreboard sb = new();
	int idle_cycles = 0;
	bit stalled_idle = 1;

	always #5 clk = ~clk;

	rotation_matrix_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.quat_w(quat_w), .degenerate(degenerate)
	);

	always @(posedge clk) begin
		quat_t got;
		if (arst_n && done) begin
			got.x = quat_x; got.y = quat_y; got.z = quat_z; got.w = quat_w;
			got.degen = degenerate;
			sb.check_quat(got);
		end
	end

	// count cycles with no item moving either way
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("rotation_matrix_to_quaternion_test NOT OK");
				$finish;
			end
		end
	end

	task automatic send_matrix(mat_t a);
		start <= 1'b1;
		m00 <= a[0]; m01 <= a[1]; m02 <= a[2];
		m10 <= a[3]; m11 <= a[4]; m12 <= a[5];
		m20 <= a[6]; m21 <= a[7]; m22 <= a[8];
		do @(posedge clk); while (busy);
		sb.note_matrix(a);
		if (stalled_idle && $urandom_range(99) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	function automatic mat_t diag_matrix(int d0, int d1, int d2);
		mat_t a;
		foreach (a[n]) a[n] = '0;
		a[0] = elem_t'(d0); a[4] = elem_t'(d1); a[8] = elem_t'(d2);
		return a;
	endfunction

	// signed permutation with small noise: near-rotations in every branch
	function automatic mat_t near_rotation();
		mat_t a;
		int perm [3];
		int p, s, idx;
		perm = '{0, 1, 2};
		p = $urandom_range(5);
		if (p & 1) begin s = perm[0]; perm[0] = perm[1]; perm[1] = s; end
		if (p >= 2) begin s = perm[2]; perm[2] = perm[p % 2]; perm[p % 2] = s; end
		foreach (a[n]) a[n] = elem_t'($signed($urandom_range(4000)) - 2000);
		for (int r = 0; r < 3; r++) begin
			idx = r * 3 + perm[r];
			a[idx] = elem_t'(int'(a[idx]) + ($urandom_range(1) ? ONE : -ONE));
		end
		return a;
	endfunction

	function automatic mat_t random_matrix();
		mat_t a;
		foreach (a[n]) a[n] = elem_t'($urandom);
		return a;
	endfunction

	initial begin
		mat_t a;
		int v;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_matrix(diag_matrix(ONE, ONE, ONE));
		send_matrix(diag_matrix(-ONE, -ONE, -ONE));
		send_matrix(diag_matrix(ONE, -ONE, -ONE));
		send_matrix(diag_matrix(-ONE, ONE, -ONE));
		send_matrix(diag_matrix(-ONE, -ONE, ONE));
		send_matrix(diag_matrix(0, 0, 0));
		send_matrix(diag_matrix(131071, 131071, 131071));
		send_matrix(diag_matrix(-131072, -131072, -131072));
		send_matrix(diag_matrix(-5, -5, -5));
		send_matrix(diag_matrix(1, 0, 0));
		foreach (a[n]) a[n] = elem_t'(131071);
		send_matrix(a);
		foreach (a[n]) a[n] = elem_t'(-131072);
		send_matrix(a);
		// quarter turns about each axis
		a = diag_matrix(ONE, 0, 0); a[5] = elem_t'(-ONE); a[7] = elem_t'(ONE); send_matrix(a);
		a = diag_matrix(0, ONE, 0); a[2] = elem_t'(ONE); a[6] = elem_t'(-ONE); send_matrix(a);
		a = diag_matrix(0, 0, ONE); a[1] = elem_t'(-ONE); a[3] = elem_t'(ONE); send_matrix(a);
		foreach (a[n]) a[n] = elem_t'((n % 2) ? 131071 : -131072);
		send_matrix(a);

		for (int it = 0; it < 550; it++) begin
			stalled_idle = !(it >= 200 && it < 350);
			v = $urandom_range(99);
			if (v < 45) a = near_rotation();
			else if (v < 55) begin
				v = -$signed($urandom_range(131072));
				a = random_matrix();
				a[0] = elem_t'(v); a[4] = elem_t'(v); a[8] = elem_t'(v);
			end else a = random_matrix();
			send_matrix(a);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0)
			$display("rotation_matrix_to_quaternion_test OK");
		else
			$display("rotation_matrix_to_quaternion_test NOT OK");
		$finish;
	end
endmodule
